// ===== design/dwlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwlr_pkg
// Types and codes shared by the deque core, its front end and its back end.
// ----------------------------------------------------------------------------
package dwlr_pkg;

  // input item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_REVERSE = 2'd1;
  localparam logic [1:0] KIND_DELETE  = 2'd2;
  localparam logic [1:0] KIND_FINISH  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // fixed field widths
  localparam int ELEMENT_BITS = 16;

  // command queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]              kind;
    logic [ELEMENT_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0] element;
    logic [1:0]              status;
    logic                    last;
  } result_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_REVERSE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [ELEMENT_BITS-1:0] value;
  } cmd_t;

endpackage

// ===== design/deque_with_lazy_reverse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_lazy_reverse_core
// Bounded ring-buffer deque with a reverse flag and a draining finish command.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item (kind, value) is taken at a clock edge where start is high
//   and busy is low. Items go into a four-entry command queue; busy is high
//   while that queue is full.
//   Output: each result sits on result for exactly one cycle with strobe high;
//   the receiver cannot stall, so nothing holds results back.
//   Load, reverse and delete are executed by the back end and give no
//   result. A finish on an error or empty store gives one result. A finish
//   with n elements first sets up the drain, then does one memory read per
//   cycle from the single read port, so results stream one per cycle in
//   logical order, last marked. The first result of an item waits behind any
//   queued work ahead of it in the command queue; a drain result also passes
//   the drain setup and the registered read.
//   Reset clears the queue, pointers, count and flags; the store itself needs
//   no clearing since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module deque_with_lazy_reverse_core #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dwlr_pkg::in_item_t item,
  output logic              strobe,
  output dwlr_pkg::result_t result
);
  import dwlr_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // front end: accept, classify, buffer
  dwlr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // back end: execute and drain
  dwlr_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// ===== design/dwlr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwlr_front
// Accepts items, decodes them into commands and buffers them in a small
// queue so the back end can stall during a drain without losing items.
// ----------------------------------------------------------------------------
module dwlr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dwlr_pkg::in_item_t item,
  output logic              q_valid,
  output dwlr_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);
  import dwlr_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  cmd_t              cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.value = item.value;
    case (item.kind)
      KIND_LOAD:    cmd_in.op = OP_LOAD;
      KIND_REVERSE: cmd_in.op = OP_REVERSE;
      KIND_DELETE:  cmd_in.op = OP_DELETE;
      KIND_FINISH:  cmd_in.op = OP_FINISH;
      default:      cmd_in.op = OP_LOAD;
    endcase
  end

  assign busy    = (q_count == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (q_count != '0);
  assign q_cmd   = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("pop from empty command queue");

  a_fill_level : assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> q_count == $past(q_count) + 1'b1)
    else $error("command queue fill level did not track a push");
`endif

endmodule

// ===== design/dwlr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwlr_back
// Executes queued commands on the ring buffer: pointer moves for load/delete,
// a reverse flip, a one-word-per-cycle drain or a status result for finish.
// ----------------------------------------------------------------------------
module dwlr_back #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dwlr_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             strobe,
  output dwlr_pkg::result_t result
);
  import dwlr_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  logic [VALUE_BITS-1:0] mem [DEPTH];

  state_t                state;
  logic [IW-1:0]         head;
  logic [CW-1:0]         count;
  logic                  reversed;
  logic                  error_seen;
  logic [IW-1:0]         rd_ptr;
  logic [CW-1:0]         rem;
  logic                  drain_rev;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic                  out_last;
  logic [VALUE_BITS-1:0] rd_data;

  logic                  we;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wdata;
  logic [IW-1:0]         head_inc;
  logic [IW-1:0]         head_dec;
  logic [IW-1:0]         tail_slot;
  logic [IW-1:0]         back_slot;
  logic [IW-1:0]         ptr_inc;
  logic [IW-1:0]         ptr_dec;

  // ring index helpers: sum of two in-range indices wraps with one subtract
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_up(input logic [IW-1:0] a);
    return (a == LAST_IX) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] a);
    return (a == '0) ? LAST_IX : a - 1'b1;
  endfunction

  assign head_inc  = step_up(head);
  assign head_dec  = step_down(head);
  assign tail_slot = wrap_add(head, count[IW-1:0]);
  assign back_slot = wrap_add(head, IW'(count - 1'b1));
  assign ptr_inc   = step_up(rd_ptr);
  assign ptr_dec   = step_down(rd_ptr);

  assign q_pop = q_valid && (state == ST_IDLE);

  // load write: value fitted to the stored word width
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      wdata[i] = (i < ELEMENT_BITS) ? q_cmd.value[i] : 1'b0;
    end
    we      = q_pop && (q_cmd.op == OP_LOAD) && (count != FULL_C);
    wr_addr = reversed ? head_dec : tail_slot;
  end

  // ring buffer storage with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    if (state == ST_DRAIN) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // command execution and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      count      <= '0;
      reversed   <= 1'b0;
      error_seen <= 1'b0;
      rem        <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_cmd.op)
              OP_LOAD: begin
                if (count != FULL_C) begin
                  if (reversed) begin
                    head <= head_dec;
                  end
                  count <= count + 1'b1;
                end
              end
              OP_REVERSE: begin
                if (!error_seen) begin
                  reversed <= !reversed;
                end
              end
              OP_DELETE: begin
                if (!error_seen) begin
                  if (count == '0) begin
                    error_seen <= 1'b1;
                  end else begin
                    if (!reversed) begin
                      head <= head_inc;
                    end
                    count <= count - 1'b1;
                  end
                end
              end
              OP_FINISH: begin
                if (error_seen || count == '0) begin
                  out_valid  <= 1'b1;
                  out_status <= error_seen ? STATUS_ERROR : STATUS_EMPTY;
                  out_last   <= 1'b1;
                end else begin
                  state     <= ST_DRAIN;
                  rd_ptr    <= reversed ? back_slot : head;
                  drain_rev <= reversed;
                  rem       <= count;
                end
                head       <= '0;
                count      <= '0;
                reversed   <= 1'b0;
                error_seen <= 1'b0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DRAIN: begin
          out_valid  <= 1'b1;
          out_status <= STATUS_OK;
          out_last   <= (rem == CW'(1));
          rd_ptr     <= drain_rev ? ptr_dec : ptr_inc;
          rem        <= rem - 1'b1;
          if (rem == CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result view: stored word fitted to the element width
  always_comb begin
    for (int i = 0; i < ELEMENT_BITS; i++) begin
      result.element[i] = (i < VALUE_BITS && out_status == STATUS_OK) ?
                          rd_data[i] : 1'b0;
    end
    result.status = out_status;
    result.last   = out_last;
  end

  assign strobe = out_valid;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= FULL_C)
    else $error("element count beyond capacity");

  a_drain_nonzero : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> rem != '0)
    else $error("drain running with nothing left");

  a_single_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != STATUS_OK) |-> (out_last && state == ST_IDLE))
    else $error("error or empty result not alone");

  a_drain_clears : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count == '0 || $past(state) == ST_IDLE) ||
                            !$past(q_pop))
    else $error("store not cleared when drain began");
`endif

endmodule

// ===== sim/tb_deque_with_lazy_reverse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_lazy_reverse_core
// Self-checking bench for the ring-buffer deque with a lazy reverse flag.
// Each accepted item runs through a local deque predictor. The predictor
// queues the results that item should produce, and each strobed result is
// compared field by field against the oldest queued one. Directed cases cover
// the empty, error, reversed-append and full-store corners. Random cases
// follow under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_deque_with_lazy_reverse_core;
  import dwlr_pkg::*;

  localparam int DEQUE_DEPTH = 64;
  localparam int DRAIN_SLACK = 20;
  localparam int EXP_DEPTH   = 256;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  in_item_t item;
  logic     strobe;
  result_t  result;

  deque_with_lazy_reverse_core #(
    .DEPTH(DEQUE_DEPTH),
    .VALUE_BITS(ELEMENT_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predictor copy of the deque
  logic [ELEMENT_BITS-1:0] shadow_mem [DEQUE_DEPTH];
  logic [5:0]              shadow_head;
  logic [6:0]              shadow_count;
  logic                    shadow_rev;
  logic                    shadow_err;

  // expected results, oldest first, held in a ring
  result_t exp_mem [EXP_DEPTH];
  int      exp_wr = 0;
  int      exp_rd = 0;

  int idle_pct      = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int finish_count  = 0;
  int error_finish  = 0;
  int empty_finish  = 0;
  int dropped_loads = 0;
  int fail_count    = 0;

  // append one expected result at the tail of the ring
  task automatic expect_result(input result_t r);
    if (exp_wr - exp_rd >= EXP_DEPTH) begin
      $error("expected result ring overflow");
      fail_count++;
    end
    exp_mem[exp_wr[7:0]] = r;
    exp_wr++;
  endtask

  // update the predictor for one accepted item and queue its results
  task automatic apply_command(input in_item_t it);
    result_t r;
    logic [5:0] off;
    int n;
    case (it.kind)
      KIND_LOAD: begin
        if (shadow_count >= DEQUE_DEPTH) begin
          dropped_loads++;
        end else begin
          // reversed: logical back sits just before the head
          if (shadow_rev) begin
            shadow_head = shadow_head - 6'd1;
            shadow_mem[shadow_head] = it.value;
          end else begin
            shadow_mem[shadow_head + shadow_count[5:0]] = it.value;
          end
          shadow_count++;
        end
      end
      KIND_REVERSE: begin
        if (!shadow_err) shadow_rev = ~shadow_rev;
      end
      KIND_DELETE: begin
        if (!shadow_err) begin
          if (shadow_count == 0) begin
            shadow_err = 1'b1;
          end else begin
            if (!shadow_rev) shadow_head = shadow_head + 6'd1;
            shadow_count--;
          end
        end
      end
      KIND_FINISH: begin
        finish_count++;
        if (shadow_err || shadow_count == 0) begin
          r.element = '0;
          r.status  = shadow_err ? STATUS_ERROR : STATUS_EMPTY;
          r.last    = 1'b1;
          if (shadow_err) error_finish++;
          else empty_finish++;
          expect_result(r);
        end else begin
          n = shadow_count;
          for (int i = 0; i < n; i++) begin
            off = shadow_rev ? 6'(n - 1 - i) : 6'(i);
            r.element = shadow_mem[shadow_head + off];
            r.status  = STATUS_OK;
            r.last    = (i + 1 == n);
            expect_result(r);
          end
        end
        shadow_head  = '0;
        shadow_count = '0;
        shadow_rev   = 1'b0;
        shadow_err   = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // send one item, idling first at the current rate
  task automatic send_item(input logic [1:0] kind, input logic [ELEMENT_BITS-1:0] value);
    in_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      it.kind  = 2'($urandom);
      it.value = 16'($urandom);
      start <= 1'b0;
      item  <= it;
    end
    it.kind  = kind;
    it.value = value;
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(it);
    sent_count++;
  endtask

  task automatic send_load(input logic [ELEMENT_BITS-1:0] value);
    send_item(KIND_LOAD, value);
  endtask

  // compare every strobed result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && strobe) begin
      checked_count++;
      if (exp_wr == exp_rd) begin
        $error("unexpected result: element %h status %0d last %0d",
               result.element, result.status, result.last);
        fail_count++;
      end else begin
        want = exp_mem[exp_rd[7:0]];
        exp_rd++;
        if (result.element !== want.element) begin
          $error("element: expected %h, got %h", want.element, result.element);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          fail_count++;
        end
      end
    end
  end

  // empty finish, sticky error and what is ignored after it
  task automatic test_empty_and_error();
    send_item(KIND_FINISH, 16'h0000);
    send_item(KIND_DELETE, 16'hFFFF);
    send_item(KIND_REVERSE, 16'h0000);
    send_item(KIND_DELETE, 16'h0000);
    send_load(16'h1234);
    send_item(KIND_FINISH, 16'hFFFF);
  endtask

  // logical order, reversed append, delete from either end
  task automatic test_order_and_reverse();
    send_load(16'h0000);
    send_load(16'hFFFF);
    send_load(16'h8000);
    send_item(KIND_FINISH, 16'h0000);
    // append while reversed wraps the head below slot zero
    send_load(16'h0001);
    send_load(16'h0002);
    send_item(KIND_REVERSE, 16'h0000);
    send_load(16'h0003);
    send_item(KIND_DELETE, 16'h0000);
    send_item(KIND_FINISH, 16'h0000);
    send_load(16'h0005);
    send_item(KIND_DELETE, 16'h0000);
    send_load(16'hAAAA);
    send_load(16'h5555);
    send_item(KIND_DELETE, 16'h0000);
    send_item(KIND_FINISH, 16'h0000);
  endtask

  // full store: drops, wrap of the ring and a 64-element drain
  task automatic test_full_store();
    for (int i = 0; i < DEQUE_DEPTH; i++) send_load(16'($urandom));
    send_load(16'($urandom));
    for (int i = 0; i < 5; i++) send_item(KIND_DELETE, 16'($urandom));
    for (int i = 0; i < 5; i++) send_load(16'($urandom));
    send_item(KIND_REVERSE, 16'($urandom));
    send_load(16'($urandom));
    send_item(KIND_FINISH, 16'($urandom));
    // fill while reversed, then drain
    send_item(KIND_REVERSE, 16'($urandom));
    for (int i = 0; i <= DEQUE_DEPTH; i++) send_load(16'($urandom));
    send_item(KIND_FINISH, 16'($urandom));
  endtask

  // one random case closed by a finish, mostly well formed
  task automatic run_random_case();
    int n_ops;
    int pick;
    n_ops = ($urandom_range(11) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_load(16'($urandom));
      end else if (pick < 65) begin
        send_item(KIND_REVERSE, 16'($urandom));
      end else if (pick < 88) begin
        // avoid deleting on empty most of the time
        if (shadow_count != 0 || $urandom_range(19) == 0)
          send_item(KIND_DELETE, 16'($urandom));
        else
          send_load(16'($urandom));
      end else if (pick < 96) begin
        send_item(KIND_DELETE, 16'($urandom));
      end else begin
        send_item(KIND_FINISH, 16'($urandom));
      end
    end
    send_item(KIND_FINISH, 16'($urandom));
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    int first;
    idle_pct = pct;
    first = sent_count;
    while (sent_count - first < n_items) run_random_case();
  endtask

  // main sequence
  initial begin
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    shadow_head  = '0;
    shadow_count = '0;
    shadow_rev   = 1'b0;
    shadow_err   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_error();
    test_order_and_reverse();
    test_full_store();
    test_random_traffic(0, 60);
    test_random_traffic(81, 60);
    test_random_traffic(11, 60);

    @(negedge clk);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("sent %0d items, checked %0d results over %0d finishes", sent_count,
             checked_count, finish_count);
    $display("%0d error finishes, %0d empty finishes, %0d loads dropped on a full store",
             error_finish, empty_finish, dropped_loads);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dwlr_pkg.sv
design/dwlr_front.sv
design/dwlr_back.sv
design/deque_with_lazy_reverse_core.sv
sim/tb_deque_with_lazy_reverse_core.sv
